[sv/chd_pkg.sv]
// shared types, constants and byte classifiers for the chunked body decoder
`default_nettype none
package chd_pkg;

  localparam int unsigned SIZE_BITS_DEFAULT = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_HT = 8'h09;

  localparam int unsigned TRAILER_BYTES = 2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.val = 4'(b - 8'h41 + 8'd10);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.val = 4'(b - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {CHAR_SP, [CHAR_HT:CHAR_CR]};
  endfunction

endpackage
`default_nettype wire

[sv/chd_parser.sv]
// chunk framing state and the per-byte step logic
`default_nettype none
module chd_parser
  import chd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] item_byte,
  input  wire logic       item_start,
  output result_t         result
);

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_EXT     = 3'd2,
    PH_EXT_CR  = 3'd3,
    PH_DATA    = 3'd4,
    PH_TRAILER = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  phase_t                 phase, phase_next, phase_cur;
  logic [SIZE_BITS-1:0]   remaining, remaining_next, remaining_cur;
  logic [1:0]             trailer_left, trailer_left_next, trailer_left_cur, trailer_dec;
  hex_t                   hex;

  always_comb begin
    // a body start clears the parser before this byte is looked at
    phase_cur        = item_start ? PH_LEAD : phase;
    remaining_cur    = item_start ? '0 : remaining;
    trailer_left_cur = item_start ? 2'd0 : trailer_left;

    hex               = hex_decode(item_byte);
    trailer_dec       = trailer_left_cur - 2'd1;
    phase_next        = phase_cur;
    remaining_next    = remaining_cur;
    trailer_left_next = trailer_left_cur;
    result.valid      = 1'b0;
    result.data       = 8'd0;
    result.kind       = KIND_DATA;

    case (phase_cur)
      PH_LEAD: begin
        if (!is_space(item_byte)) begin
          if (!hex.ok) begin
            phase_next   = PH_DONE;
            result.valid = 1'b1;
            result.kind  = KIND_END;
          end else begin
            remaining_next = {{(SIZE_BITS-4){1'b0}}, hex.val};
            phase_next     = PH_DIGITS;
          end
        end
      end
      PH_DIGITS: begin
        if (hex.ok) begin
          if (remaining_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_next   = PH_DONE;
            result.valid = 1'b1;
            result.kind  = KIND_ERROR;
          end else begin
            remaining_next = {remaining_cur[SIZE_BITS-5:0], hex.val};
          end
        end else if (remaining_cur == '0) begin
          phase_next   = PH_DONE;
          result.valid = 1'b1;
          result.kind  = KIND_END;
        end else begin
          phase_next = (item_byte == CHAR_CR) ? PH_EXT_CR : PH_EXT;
        end
      end
      PH_EXT: begin
        if (item_byte == CHAR_CR) begin
          phase_next = PH_EXT_CR;
        end
      end
      PH_EXT_CR: begin
        if (item_byte == CHAR_LF) begin
          phase_next = PH_DATA;
        end else if (item_byte != CHAR_CR) begin
          phase_next = PH_EXT;
        end
      end
      PH_DATA: begin
        remaining_next = remaining_cur - SIZE_BITS'(1);
        if (remaining_cur == SIZE_BITS'(1)) begin
          phase_next        = PH_TRAILER;
          trailer_left_next = 2'(TRAILER_BYTES);
        end
        result.valid = 1'b1;
        result.data  = item_byte;
        result.kind  = KIND_DATA;
      end
      PH_TRAILER: begin
        trailer_left_next = trailer_dec;
        if (trailer_dec == 2'd0) begin
          phase_next = PH_LEAD;
        end
      end
      default: begin
        // done: drop everything until the next body start
      end
    endcase

    if (!fire) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      remaining    <= '0;
      trailer_left <= 2'd0;
    end else if (fire) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      trailer_left <= trailer_left_next;
    end
  end

endmodule
`default_nettype wire

[sv/chd_out_reg.sv]
// result register on the output channel
`default_nettype none
module chd_out_reg
  import chd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire result_t    result,
  input  wire logic       out_stall,
  output logic            room,
  output logic            out_valid,
  output logic [7:0]      payload_byte,
  output logic [1:0]      kind
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      payload_byte <= result.data;
      kind         <= result.kind;
    end
  end

endmodule
`default_nettype wire

[sv/http_chunked_body_decoder_unit.sv]
// top level of the chunked transfer body decoder
// a byte passes from the input register through the parser into the result register
// throughput: one byte per cycle, unless out_stall holds both single-entry registers
// a byte that makes no result leaves the input register without touching the output side
// reset (rst, synchronous, active high) empties both registers and puts the parser
// back at the start of a size field
`default_nettype none
module http_chunked_body_decoder_unit
  import chd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] body_byte,
  input  wire logic       body_start,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      payload_byte,
  output logic [1:0]      kind
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  logic       room;
  logic       fire;
  logic       in_accept;
  result_t    result;

  // the held byte is worked on once the result register can take a transfer
  assign fire      = s1_valid && room;
  assign in_stall  = s1_valid && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of the input register, loaded on each accepted transfer
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte  <= body_byte;
      s1_start <= body_start;
    end
  end

  // framing state and the per-byte decision
  chd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item_byte  (s1_byte),
    .item_start (s1_start),
    .result     (result)
  );

  // result register, also tells the parser when there is room
  chd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .out_stall    (out_stall),
    .room         (room),
    .out_valid    (out_valid),
    .payload_byte (payload_byte),
    .kind         (kind)
  );

endmodule
`default_nettype wire
